### sv/rcfd_pkg.sv
package rcfd_pkg;

   localparam logic [7:0]         TRAILER_OK    = 8'h8B;
   localparam logic [13:0]        THR_MAX_SMALL = 14'd950;
   localparam logic [13:0]        THR_MAX_BIG   = 14'd10000;
   localparam logic signed [16:0] CENTER_SMALL  = 17'sd50;
   localparam logic signed [16:0] CENTER_BIG    = 17'sd200;

   // Airframe mode codes; the unused fourth code decodes like brushless.
   localparam logic [1:0] MODE_BRUSHED   = 2'd0;
   localparam logic [1:0] MODE_WING      = 2'd1;
   localparam logic [1:0] MODE_BRUSHLESS = 2'd2;
   localparam logic [1:0] MODE_SPARE     = 2'd3;

   // Configuration register indexes.
   localparam logic [1:0] REG_AIRFRAME_MODE = 2'd0;
   localparam logic [1:0] REG_LOSS_LIMIT    = 2'd1;
   localparam logic [1:0] REG_DEAD_BAND     = 2'd2;
   localparam logic [1:0] REG_DECAY_FLOOR   = 2'd3;

   localparam int CSR_WIDTH = 14;

   typedef struct packed {
      logic [1:0]  airframe_mode;
      logic [7:0]  loss_limit;
      logic [7:0]  dead_band;
      logic [13:0] decay_floor;
   } rcfd_config_type;

   // Packed with byte1 in the lowest bits, as on the input bus.
   typedef struct packed {
      logic [7:0] trailer_byte;
      logic [7:0] byte8;
      logic [7:0] byte7;
      logic [7:0] byte6;
      logic [7:0] byte5;
      logic [7:0] byte4;
      logic [7:0] byte3;
      logic [7:0] byte2;
      logic [7:0] byte1;
   } rcfd_frame_type;

   typedef struct packed {
      logic [7:0]         miss_count;
      logic               lost_flag;
      logic [13:0]        throttle;
      logic signed [16:0] pitch;
      logic signed [16:0] roll;
      logic signed [16:0] yaw;
      logic [7:0]         left_key;
      logic [7:0]         right_key;
   } rcfd_state_type;

   typedef struct packed {
      logic               frame_accepted;
      logic               link_lost;
      logic [7:0]         right_key;
      logic [7:0]         left_key;
      logic signed [16:0] yaw;
      logic signed [16:0] roll;
      logic signed [16:0] pitch;
      logic [13:0]        throttle;
   } rcfd_result_type;

endpackage

### sv/rcfd_decode.sv
module rcfd_decode
   import rcfd_pkg::*;
(
   input  rcfd_config_type cfg,
   input  rcfd_state_type  state_cur,
   input  logic            frame_present,
   input  rcfd_frame_type  frame,
   output rcfd_state_type  state_nxt,
   output logic            frame_accepted
);

   logic               small_mode;
   logic               trailer_ok;
   logic [15:0]        thr_raw;
   logic [13:0]        thr_max;
   logic [13:0]        thr_clamped;
   logic [13:0]        thr_decoded;
   logic signed [16:0] small_a;
   logic signed [16:0] small_b;
   logic signed [16:0] small_c;
   logic signed [16:0] big_pitch;
   logic signed [16:0] big_roll;
   logic signed [16:0] big_yaw;
   logic signed [16:0] pitch_raw;
   logic signed [16:0] roll_raw;
   logic signed [16:0] yaw_raw;
   logic [7:0]         miss_next;

   function automatic logic signed [16:0] band_zero(input logic signed [16:0] v,
                                                    input logic [7:0] band);
      logic signed [16:0] b;
      b = $signed({9'd0, band});
      band_zero = (v >= -b && v <= b) ? 17'sd0 : v;
   endfunction

   assign small_mode = (cfg.airframe_mode == MODE_BRUSHED) ||
                       (cfg.airframe_mode == MODE_WING);
   assign trailer_ok = (frame.trailer_byte == TRAILER_OK);

   assign thr_raw     = {frame.byte2, frame.byte1};
   assign thr_max     = small_mode ? THR_MAX_SMALL : THR_MAX_BIG;
   assign thr_clamped = (thr_raw > {2'd0, thr_max}) ? thr_max : thr_raw[13:0];
   assign thr_decoded = (thr_clamped <= {6'd0, cfg.dead_band}) ? 14'd0 : thr_clamped;

   // Small modes read each axis as a signed byte.
   assign small_a = $signed({{9{frame.byte3[7]}}, frame.byte3}) - CENTER_SMALL;
   assign small_b = $signed({{9{frame.byte4[7]}}, frame.byte4}) - CENTER_SMALL;
   assign small_c = $signed({{9{frame.byte5[7]}}, frame.byte5}) - CENTER_SMALL;

   // Brushless mode reads 16-bit words; the negated result still fits 17 bits.
   assign big_pitch = CENTER_BIG - $signed({1'b0, frame.byte4, frame.byte3});
   assign big_roll  = CENTER_BIG - $signed({1'b0, frame.byte6, frame.byte5});
   assign big_yaw   = CENTER_BIG - $signed({1'b0, frame.byte8, frame.byte7});

   always_comb begin
      unique case (cfg.airframe_mode)
         MODE_BRUSHED: begin
            pitch_raw = -small_a;
            roll_raw  = -small_b;
            yaw_raw   = small_c;
         end
         MODE_WING: begin
            pitch_raw = -small_a;
            yaw_raw   = small_b;
            roll_raw  = -small_c;
         end
         default: begin
            pitch_raw = big_pitch;
            roll_raw  = big_roll;
            yaw_raw   = big_yaw;
         end
      endcase
   end

   assign miss_next = (state_cur.miss_count < cfg.loss_limit) ?
                      state_cur.miss_count + 8'd1 : state_cur.miss_count;

   always_comb begin
      state_nxt      = state_cur;
      frame_accepted = 1'b0;
      if (frame_present) begin
         if (trailer_ok) begin
            frame_accepted       = 1'b1;
            state_nxt.miss_count = 8'd0;
            state_nxt.lost_flag  = 1'b0;
            state_nxt.throttle   = thr_decoded;
            state_nxt.pitch      = band_zero(pitch_raw, cfg.dead_band);
            state_nxt.roll       = band_zero(roll_raw, cfg.dead_band);
            state_nxt.yaw        = band_zero(yaw_raw, cfg.dead_band);
            state_nxt.left_key   = small_mode ? frame.byte6 : 8'd0;
            state_nxt.right_key  = small_mode ? frame.byte7 : 8'd0;
         end
      end else begin
         state_nxt.miss_count = miss_next;
         // Below the limit the link stays normal; at or past it the link is lost.
         state_nxt.lost_flag  = (miss_next >= cfg.loss_limit);
         if (miss_next >= cfg.loss_limit && state_cur.throttle > cfg.decay_floor) begin
            state_nxt.throttle = state_cur.throttle - 14'd1;
         end
      end
   end

endmodule

### sv/rc_command_frame_decoder.sv
// Channel   Direction  Ports                         Contents
// req       in         req_tvalid/tready/tdata/tuser one radio poll
// rsp       out        rsp_tvalid/tready/tdata/tuser decoded commands and link status
// csr       in         csr_we/csr_index/csr_wdata    four configuration registers
//
// Each poll is decoded in the cycle it is accepted and its result is registered
// in the output register, or in the skid register while rsp stalls; one item per
// cycle is sustained while rsp_tready is high. The skid register lets req accept
// one more poll after rsp stalls; req_tready drops only when both are full.
// Synchronous active-high reset clears the link state and the commands to zero
// and loads the configuration defaults.
module rc_command_frame_decoder
   import rcfd_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   // byte1, byte2, byte3, byte4, byte5, byte6, byte7, byte8, trailer_byte
   input  logic [71:0]          req_tdata,
   // frame_present
   input  logic                 req_tuser,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   // throttle_out[13:0], pitch_out[30:14], roll_out[47:31], yaw_out[64:48],
   // left_key[72:65], right_key[80:73], zero fill
   output logic [87:0]          rsp_tdata,
   // link_lost, frame_accepted
   output logic [1:0]           rsp_tuser,
   input  logic                 csr_we,
   input  logic [1:0]           csr_index,
   input  logic [CSR_WIDTH-1:0] csr_wdata
);

   rcfd_config_type cfg_ff;
   rcfd_state_type  state_ff;
   rcfd_state_type  state_in;
   rcfd_result_type result_in;
   rcfd_result_type out_ff;
   rcfd_result_type skid_ff;
   logic            out_valid_ff;
   logic            skid_valid_ff;
   logic            accepted_in;
   logic            req_accept;
   logic            rsp_take;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.airframe_mode <= MODE_BRUSHED;
         cfg_ff.loss_limit    <= 8'd200;
         cfg_ff.dead_band     <= 8'd5;
         cfg_ff.decay_floor   <= 14'd10;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_AIRFRAME_MODE: cfg_ff.airframe_mode <= csr_wdata[1:0];
            REG_LOSS_LIMIT:    cfg_ff.loss_limit    <= csr_wdata[7:0];
            REG_DEAD_BAND:     cfg_ff.dead_band     <= csr_wdata[7:0];
            REG_DECAY_FLOOR:   cfg_ff.decay_floor   <= csr_wdata[13:0];
            default: ;
         endcase
      end
   end

   rcfd_decode u_decode (
      .cfg            (cfg_ff),
      .state_cur      (state_ff),
      .frame_present  (req_tuser),
      .frame          (rcfd_frame_type'(req_tdata)),
      .state_nxt      (state_in),
      .frame_accepted (accepted_in)
   );

   assign req_tready = !skid_valid_ff;
   assign req_accept = req_tvalid && req_tready;
   assign rsp_take   = out_valid_ff && rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (req_accept) begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      result_in.frame_accepted = accepted_in;
      result_in.link_lost      = state_in.lost_flag;
      result_in.right_key      = state_in.right_key;
      result_in.left_key       = state_in.left_key;
      result_in.yaw            = state_in.yaw;
      result_in.roll           = state_in.roll;
      result_in.pitch          = state_in.pitch;
      result_in.throttle       = state_in.throttle;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (!out_valid_ff || rsp_take) begin
         if (skid_valid_ff) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            out_valid_ff  <= req_accept;
         end
      end else if (req_accept) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!out_valid_ff || rsp_take) begin
         if (skid_valid_ff) begin
            out_ff <= skid_ff;
         end else if (req_accept) begin
            out_ff <= result_in;
         end
      end else if (req_accept) begin
         skid_ff <= result_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {7'd0, out_ff.right_key, out_ff.left_key, out_ff.yaw,
                        out_ff.roll, out_ff.pitch, out_ff.throttle};
   assign rsp_tuser  = {out_ff.frame_accepted, out_ff.link_lost};

   a_accept_gives_result: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> rsp_tvalid)
      else $error("accepted item did not produce a result");

   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid register holds an item while output register is empty");

   a_accept_clears_lost: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[1]) |-> !rsp_tuser[0])
      else $error("accepted frame reported with link lost");

   a_throttle_range: assert property (@(posedge clock) disable iff (reset)
      state_ff.throttle <= THR_MAX_BIG)
      else $error("throttle state above clamp");

endmodule
